// ----- src/bresenham_line_stepper_assert.svh -----
// assertion macros shared by the line stepper modules
// expects clk and rst_n in the scope of each use
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BLS_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define BLS_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BLS_CHECK(name, ante, cons, msg)
`define BLS_CHECK_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- src/bls_pkg.sv -----
// shared types and constants of the line stepper
// no dependencies
package bls_pkg;

    // configuration register map
    localparam int CFG_W = 14;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] VIEWPORT_RESET = 14'd1024;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic      valid;
        cmd_kind_t kind;
    } q_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_WALK,
        ST_DIVI,
        ST_DIV,
        ST_MIXA,
        ST_MIXB,
        ST_OUT
    } back_state_t;

endpackage

// ----- src/bls_cmd_if.sv -----
// command channel carrying start and step items
// no dependencies
interface bls_cmd_if #(
    parameter int COORD_BITS = 14,
    parameter int DEPTH_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [DEPTH_BITS-1:0] start_depth;
    logic [DEPTH_BITS-1:0] end_depth;

    modport source (output valid, mode, start_x, start_y, end_x, end_y,
                    start_depth, end_depth, input ready);
    modport sink (input valid, mode, start_x, start_y, end_x, end_y,
                  start_depth, end_depth, output ready);
endinterface

// ----- src/bls_pix_if.sv -----
// pixel channel carrying one result pixel per transfer
// no dependencies
interface bls_pix_if #(
    parameter int COORD_BITS = 14,
    parameter int DEPTH_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [DEPTH_BITS-1:0] pixel_depth;
    logic                  inside_res;
    logic [COORD_BITS-1:0] step_index;
    logic                  last;

    modport source (output valid, pixel_x, pixel_y, pixel_depth, inside_res,
                    step_index, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_depth, inside_res,
                  step_index, last, output ready);
endinterface

// ----- src/bls_front.sv -----
// front end: accepts commands, classifies them and queues them for the back end
// depends on bls_pkg, bls_cmd_if and the assertion macro header
`include "bresenham_line_stepper_assert.svh"

module bls_front #(
    parameter int COORD_BITS = 14,
    parameter int DEPTH_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    bls_cmd_if.sink                 cmd,
    output bls_pkg::q_head_t        head,
    output logic [COORD_BITS-1:0]   head_sx,
    output logic [COORD_BITS-1:0]   head_sy,
    output logic [COORD_BITS-1:0]   head_ex,
    output logic [COORD_BITS-1:0]   head_ey,
    output logic [DEPTH_BITS-1:0]   head_za,
    output logic [DEPTH_BITS-1:0]   head_zb,
    input  logic                    pop
);
    localparam int EW = 4 * COORD_BITS + 2 * DEPTH_BITS + 1;
    localparam int PTR_W = $clog2(bls_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bls_pkg::QUEUE_DEPTH + 1);

    logic [EW-1:0]    mem_reg [bls_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    bls_pkg::cmd_kind_t kind_in;
    logic [EW-1:0]    entry_in;
    logic [EW-1:0]    entry_out;

    // classify the incoming item
    assign kind_in = cmd.mode ? bls_pkg::CMD_STEP : bls_pkg::CMD_START;
    assign entry_in = {kind_in, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
                       cmd.start_depth, cmd.end_depth};

    assign cmd.ready = (cnt_reg != CNT_W'(bls_pkg::QUEUE_DEPTH));
    assign push = cmd.valid && cmd.ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bls_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bls_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    // head of queue
    assign entry_out = mem_reg[rd_ptr_reg];
    assign head.valid = (cnt_reg != '0);
    assign head.kind = bls_pkg::cmd_kind_t'(entry_out[EW-1]);
    assign {head_sx, head_sy, head_ex, head_ey, head_za, head_zb} = entry_out[EW-2:0];

    `BLS_CHECK(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(bls_pkg::QUEUE_DEPTH), "queue overfilled")
    `BLS_CHECK(a_pop_nonempty, pop, cnt_reg != '0, "pop from empty queue")
    `BLS_CHECK_NEXT(a_push_lands, push && !pop, cnt_reg != '0, "push lost")

endmodule

// ----- src/bls_back.sv -----
// back end: line setup, square root, Bresenham walk, serial divide, depth mix
// depends on bls_pkg, bls_pix_if and the assertion macro header
`include "bresenham_line_stepper_assert.svh"

module bls_back #(
    parameter int COORD_BITS = 14,
    parameter int DEPTH_BITS = 16,
    parameter int LENGTH_FRAC_BITS = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bls_pkg::q_head_t             head,
    input  logic [COORD_BITS-1:0]        head_sx,
    input  logic [COORD_BITS-1:0]        head_sy,
    input  logic [COORD_BITS-1:0]        head_ex,
    input  logic [COORD_BITS-1:0]        head_ey,
    input  logic [DEPTH_BITS-1:0]        head_za,
    input  logic [DEPTH_BITS-1:0]        head_zb,
    output logic                         pop,
    input  logic [bls_pkg::CFG_W-1:0]    vw,
    input  logic [bls_pkg::CFG_W-1:0]    vh,
    bls_pix_if.source                    pix
);
    localparam int C = COORD_BITS;
    localparam int D = DEPTH_BITS;
    localparam int F = LENGTH_FRAC_BITS;
    localparam int E_W = C + 2;
    localparam int SQ_W = 2 * C + 1;
    localparam int R_W = (SQ_W + 2 * F + 1) / 2;
    localparam int RAD_W = 2 * R_W;
    localparam int REM_W = R_W + 2;
    localparam int Q_W = D + 1;
    localparam int NUM_W = C + F + D;
    localparam int MAXI = (R_W > Q_W) ? R_W : Q_W;
    localparam int CNT_W = $clog2(MAXI);
    localparam int P_W = D + Q_W;
    localparam logic [Q_W-1:0] ONE = Q_W'(1) << D;
    localparam logic [P_W:0] HALF = (P_W + 1)'(1) << (D - 1);

    bls_pkg::back_state_t state_reg, state_next;

    logic [C-1:0]       cur_x_reg, cur_y_reg, dest_x_reg, dest_y_reg;
    logic [C-1:0]       dx_reg, dy_reg;
    logic               neg_x_reg, neg_y_reg;
    logic signed [E_W-1:0] err_reg;
    logic [C-1:0]       count_reg;
    logic [D-1:0]       za_reg, zb_reg;
    logic               active_reg, last_reg;
    logic [SQ_W-1:0]    prod_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [R_W-1:0]     root_reg;
    logic [R_W-1:0]     len_reg;
    logic [R_W-1:0]     drem_reg;
    logic [Q_W-1:0]     nlow_reg;
    logic [Q_W-1:0]     q_reg;
    logic [Q_W-1:0]     t_reg;
    logic [P_W-1:0]     prod_a_reg, prod_b_reg;
    logic [CNT_W-1:0]   iter_reg;

    logic               pix_valid_reg;
    logic [C-1:0]       px_reg, py_reg, pidx_reg;
    logic [D-1:0]       pz_reg;
    logic               pin_reg, plast_reg;

    // start setup terms
    logic               lt_x, lt_y;
    logic [C:0]         diff_x, diff_y;
    logic [C-1:0]       sdx, sdy;
    logic signed [E_W-1:0] err_init;
    // walk terms
    logic               c1, c2;
    logic [C-1:0]       nx, ny;
    logic signed [E_W-1:0] err_step;
    // root terms
    logic [REM_W-1:0]   rem_sh, trial;
    logic               r_ge;
    // divide terms
    logic [R_W:0]       dsh;
    logic               d_ge;
    logic [NUM_W-1:0]   n_val;
    // output terms
    logic [Q_W-1:0]     t_sat;
    logic [P_W:0]       mix_sum;
    logic               in_view;
    logic               load_out;

    // endpoint deltas and directions
    assign lt_x = $signed(head_sx) < $signed(head_ex);
    assign lt_y = $signed(head_sy) < $signed(head_ey);
    assign diff_x = lt_x ? ({head_ex[C-1], head_ex} - {head_sx[C-1], head_sx})
                         : ({head_sx[C-1], head_sx} - {head_ex[C-1], head_ex});
    assign diff_y = lt_y ? ({head_ey[C-1], head_ey} - {head_sy[C-1], head_sy})
                         : ({head_sy[C-1], head_sy} - {head_ey[C-1], head_ey});
    assign sdx = diff_x[C-1:0];
    assign sdy = diff_y[C-1:0];
    assign err_init = (sdx > sdy) ? $signed({2'b00, sdx >> 1})
                                  : -$signed({2'b00, sdy >> 1});

    // one Bresenham step
    assign c1 = err_reg > -$signed({2'b00, dx_reg});
    assign c2 = err_reg < $signed({2'b00, dy_reg});
    assign nx = cur_x_reg + (c1 ? (neg_x_reg ? {C{1'b1}} : C'(1)) : '0);
    assign ny = cur_y_reg + (c2 ? (neg_y_reg ? {C{1'b1}} : C'(1)) : '0);
    assign err_step = err_reg - (c1 ? $signed({2'b00, dy_reg}) : E_W'(0))
                              + (c2 ? $signed({2'b00, dx_reg}) : E_W'(0));

    // square root digit step
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign r_ge = rem_sh >= trial;

    // restoring divide step
    assign dsh = {drem_reg, nlow_reg[Q_W-1]};
    assign d_ge = dsh >= {1'b0, len_reg};
    assign n_val = {count_reg, (F + D)'(0)};

    // depth mix and viewport test
    assign t_sat = (q_reg > ONE) ? ONE : q_reg;
    assign mix_sum = (P_W + 1)'(prod_a_reg) + (P_W + 1)'(prod_b_reg) + HALF;
    assign in_view = !cur_x_reg[C-1] && !cur_y_reg[C-1]
                     && (32'(cur_x_reg) < 32'(vw)) && (32'(cur_y_reg) < 32'(vh));
    assign load_out = (state_reg == bls_pkg::ST_OUT) && (!pix_valid_reg || pix.ready);

    assign pop = (state_reg == bls_pkg::ST_IDLE) && head.valid;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bls_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.kind == bls_pkg::CMD_START)
                    begin
                        state_next = bls_pkg::ST_SQX;
                    end
                    else if (active_reg)
                    begin
                        state_next = bls_pkg::ST_WALK;
                    end
                end
            end
            bls_pkg::ST_SQX:  state_next = bls_pkg::ST_SQY;
            bls_pkg::ST_SQY:  state_next = bls_pkg::ST_ROOT;
            bls_pkg::ST_ROOT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = bls_pkg::ST_DIVI;
                end
            end
            bls_pkg::ST_WALK: state_next = bls_pkg::ST_DIVI;
            bls_pkg::ST_DIVI:
            begin
                state_next = (len_reg == '0) ? bls_pkg::ST_MIXA : bls_pkg::ST_DIV;
            end
            bls_pkg::ST_DIV:
            begin
                if (iter_reg == '0)
                begin
                    state_next = bls_pkg::ST_MIXA;
                end
            end
            bls_pkg::ST_MIXA: state_next = bls_pkg::ST_MIXB;
            bls_pkg::ST_MIXB: state_next = bls_pkg::ST_OUT;
            bls_pkg::ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = bls_pkg::ST_IDLE;
                end
            end
            default:          state_next = bls_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bls_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // line control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            last_reg <= 1'b0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            dest_x_reg <= '0;
            dest_y_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            neg_x_reg <= 1'b0;
            neg_y_reg <= 1'b0;
            err_reg <= '0;
            count_reg <= '0;
            len_reg <= '0;
            za_reg <= '0;
            zb_reg <= '0;
        end
        else if (pop && head.kind == bls_pkg::CMD_START)
        begin
            cur_x_reg <= head_sx;
            cur_y_reg <= head_sy;
            dest_x_reg <= head_ex;
            dest_y_reg <= head_ey;
            za_reg <= head_za;
            zb_reg <= head_zb;
            dx_reg <= sdx;
            dy_reg <= sdy;
            neg_x_reg <= !lt_x;
            neg_y_reg <= !lt_y;
            err_reg <= err_init;
            count_reg <= '0;
            last_reg <= (head_sx == head_ex) && (head_sy == head_ey);
            active_reg <= !((head_sx == head_ex) && (head_sy == head_ey));
        end
        else if (state_reg == bls_pkg::ST_WALK)
        begin
            cur_x_reg <= nx;
            cur_y_reg <= ny;
            err_reg <= err_step;
            count_reg <= count_reg + C'(1);
            last_reg <= (nx == dest_x_reg) && (ny == dest_y_reg);
            if ((nx == dest_x_reg) && (ny == dest_y_reg))
            begin
                active_reg <= 1'b0;
            end
        end
        else if (state_reg == bls_pkg::ST_ROOT && iter_reg == '0)
        begin
            len_reg <= {root_reg[R_W-2:0], r_ge};
        end
    end

    // arithmetic datapath: squares, root, divide, mix
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bls_pkg::ST_SQX:
            begin
                prod_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            end
            bls_pkg::ST_SQY:
            begin
                rad_reg <= RAD_W'(prod_reg + SQ_W'(dy_reg) * SQ_W'(dy_reg)) << (2 * F);
                rem_reg <= '0;
                root_reg <= '0;
                iter_reg <= CNT_W'(R_W - 1);
            end
            bls_pkg::ST_ROOT:
            begin
                rem_reg <= r_ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[R_W-2:0], r_ge};
                rad_reg <= rad_reg << 2;
                iter_reg <= iter_reg - CNT_W'(1);
            end
            bls_pkg::ST_DIVI:
            begin
                drem_reg <= R_W'(n_val >> Q_W);
                nlow_reg <= n_val[Q_W-1:0];
                q_reg <= (len_reg == '0) ? ONE : '0;
                iter_reg <= CNT_W'(Q_W - 1);
            end
            bls_pkg::ST_DIV:
            begin
                drem_reg <= d_ge ? R_W'(dsh - {1'b0, len_reg}) : R_W'(dsh);
                nlow_reg <= nlow_reg << 1;
                q_reg <= {q_reg[Q_W-2:0], d_ge};
                iter_reg <= iter_reg - CNT_W'(1);
            end
            bls_pkg::ST_MIXA:
            begin
                t_reg <= t_sat;
                prod_a_reg <= P_W'(za_reg) * P_W'(ONE - t_sat);
            end
            bls_pkg::ST_MIXB:
            begin
                prod_b_reg <= P_W'(zb_reg) * P_W'(t_reg);
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            px_reg <= cur_x_reg;
            py_reg <= cur_y_reg;
            pz_reg <= mix_sum[D +: D];
            pin_reg <= in_view;
            pidx_reg <= count_reg;
            plast_reg <= last_reg;
        end
    end

    assign pix.valid = pix_valid_reg;
    assign pix.pixel_x = px_reg;
    assign pix.pixel_y = py_reg;
    assign pix.pixel_depth = pz_reg;
    assign pix.inside_res = pin_reg;
    assign pix.step_index = pidx_reg;
    assign pix.last = plast_reg;

    `BLS_CHECK(a_div_nonzero, state_reg == bls_pkg::ST_DIV, len_reg != '0, "divide by zero length")
    `BLS_CHECK(a_walk_active, state_reg == bls_pkg::ST_WALK, active_reg, "walk on idle line")
    `BLS_CHECK_NEXT(a_last_ends, load_out && last_reg, !active_reg, "line active after last pixel")

endmodule

// ----- src/bresenham_line_stepper.sv -----
// Bresenham line stepper. A start command (mode 0) loads two endpoints and their
// depths and yields the first pixel; each step command (mode 1) yields the next
// pixel, or nothing once the line's end point has been sent. Commands pass through
// a two-entry queue into one shared sequencer. A start squares both deltas, takes a
// square root of one result bit per cycle, then runs a one-bit-per-cycle divide and
// the depth mix and output states; a step makes one walk move, then runs that
// serial divide and the mix and output states. The pixel output register lets the
// next command start while a pixel waits to be taken.
// depends on bls_pkg, bls_cmd_if, bls_pix_if, bls_front and bls_back
module bresenham_line_stepper #(
    parameter int COORD_BITS = 14,
    parameter int DEPTH_BITS = 16,
    parameter int LENGTH_FRAC_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bls_cmd_if.sink                           cmd,
    bls_pix_if.source                         pix,
    input  logic                              cfg_we,
    input  logic [bls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bls_pkg::CFG_W-1:0]         cfg_data
);
    bls_pkg::q_head_t         head;
    logic [COORD_BITS-1:0]    head_sx, head_sy, head_ex, head_ey;
    logic [DEPTH_BITS-1:0]    head_za, head_zb;
    logic                     pop;
    logic [bls_pkg::CFG_W-1:0] vw_reg, vh_reg;

    // viewport registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= bls_pkg::VIEWPORT_RESET;
            vh_reg <= bls_pkg::VIEWPORT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bls_pkg::CFG_VIEWPORT_WIDTH:  vw_reg <= cfg_data;
                bls_pkg::CFG_VIEWPORT_HEIGHT: vh_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // command intake and queue
    bls_front #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .head    (head),
        .head_sx (head_sx),
        .head_sy (head_sy),
        .head_ex (head_ex),
        .head_ey (head_ey),
        .head_za (head_za),
        .head_zb (head_zb),
        .pop     (pop)
    );

    // line sequencer
    bls_back #(
        .COORD_BITS       (COORD_BITS),
        .DEPTH_BITS       (DEPTH_BITS),
        .LENGTH_FRAC_BITS (LENGTH_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .head_sx (head_sx),
        .head_sy (head_sy),
        .head_ex (head_ex),
        .head_ey (head_ey),
        .head_za (head_za),
        .head_zb (head_zb),
        .pop     (pop),
        .vw      (vw_reg),
        .vh      (vh_reg),
        .pix     (pix)
    );

endmodule

// ----- sim/bresenham_line_stepper_tb.sv -----
// self-checking testbench for the bresenham line stepper
// depends on bls_pkg, bls_cmd_if, bls_pix_if and bresenham_line_stepper
module bresenham_line_stepper_tb;

    localparam int CW = 14;
    localparam int DW = 16;
    localparam int SETTLE_CYCLES = 80;
    localparam longint LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [DW-1:0] depth;
        logic          in_view;
        logic [CW-1:0] index;
        logic          last;
    } pixel_t;

    typedef struct {
        bls_pkg::cmd_kind_t kind;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic [DW-1:0] za;
        logic [DW-1:0] zb;
        bit            typed;
        pixel_t        want;
    } cmd_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bls_pkg::CFG_W-1:0] cfg_data = '0;

    bls_cmd_if #(.COORD_BITS(CW), .DEPTH_BITS(DW)) cmd_ch ();
    bls_pix_if #(.COORD_BITS(CW), .DEPTH_BITS(DW)) pix_ch ();

    bresenham_line_stepper #(.COORD_BITS(CW), .DEPTH_BITS(DW), .LENGTH_FRAC_BITS(6)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .pix       (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // shadow state of the line walker
    int unsigned vp_w = 1024;
    int unsigned vp_h = 1024;
    int cx, cy, dx_end, dy_end, adx, ady, sgx, sgy, err_acc;
    int unsigned walk_count;
    longint unsigned seg_len;
    longint unsigned za_hold, zb_hold;
    bit walking;

    pixel_t pending_pixels[$];
    int errors = 0;
    bit rx_quiet = 1'b0;
    bit tx_quiet = 1'b0;

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // pixel at the current walk position
    function automatic pixel_t current_pixel(bit at_end);
        pixel_t p;
        longint unsigned t, one;
        one = 64'd1 << DW;
        if (seg_len == 0)
            t = one;
        else
        begin
            t = (longint'(walk_count) << (6 + DW)) / seg_len;
            if (t > one)
                t = one;
        end
        p.x = cx[CW-1:0];
        p.y = cy[CW-1:0];
        p.depth = DW'((za_hold * (one - t) + zb_hold * t + (one >> 1)) >> DW);
        p.in_view = cx >= 0 && cy >= 0 && cx < int'(vp_w) && cy < int'(vp_h);
        p.index = walk_count[CW-1:0];
        p.last = at_end;
        return p;
    endfunction

    // advance the shadow walker by one transfer; returns 1 when a pixel is due
    function automatic bit walk_update(cmd_row_t c, output pixel_t p);
        int e2;
        bit at_end;
        longint unsigned sq;
        if (c.kind == bls_pkg::CMD_START)
        begin
            cx = $signed(c.sx);
            cy = $signed(c.sy);
            dx_end = $signed(c.ex);
            dy_end = $signed(c.ey);
            za_hold = c.za;
            zb_hold = c.zb;
            adx = cx < dx_end ? dx_end - cx : cx - dx_end;
            ady = cy < dy_end ? dy_end - cy : cy - dy_end;
            sgx = cx < dx_end ? 1 : -1;
            sgy = cy < dy_end ? 1 : -1;
            err_acc = adx > ady ? adx / 2 : -(ady / 2);
            walk_count = 0;
            sq = longint'(adx) * adx + longint'(ady) * ady;
            seg_len = int_root(sq << 12);
            at_end = cx == dx_end && cy == dy_end;
            walking = !at_end;
            p = current_pixel(at_end);
            return 1'b1;
        end
        if (!walking)
            return 1'b0;
        e2 = err_acc;
        if (e2 > -adx)
        begin
            err_acc -= ady;
            cx += sgx;
        end
        if (e2 < ady)
        begin
            err_acc += adx;
            cy += sgy;
        end
        walk_count++;
        at_end = cx == dx_end && cy == dy_end;
        if (at_end)
            walking = 1'b0;
        p = current_pixel(at_end);
        return 1'b1;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // drive one command and wait for its transfer; called at a falling edge
    task automatic send_cmd(cmd_row_t c);
        int g;
        pixel_t p;
        g = pick_gap(tx_quiet);
        repeat (g)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode <= c.kind;
        cmd_ch.start_x <= c.sx;
        cmd_ch.start_y <= c.sy;
        cmd_ch.end_x <= c.ex;
        cmd_ch.end_y <= c.ey;
        cmd_ch.start_depth <= c.za;
        cmd_ch.end_depth <= c.zb;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (walk_update(c, p))
            pending_pixels.insert(pending_pixels.size(), c.typed ? c.want : p);
        @(negedge clk);
    endtask

    // wait until every pixel is back and the sequencer has settled
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [bls_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= bls_pkg::CFG_W'(val);
        if (idx == bls_pkg::CFG_VIEWPORT_WIDTH)
            vp_w = val & 16'h3FFF;
        else
            vp_h = val & 16'h3FFF;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic cmd_row_t mk(bls_pkg::cmd_kind_t k, int sx, int sy, int ex, int ey,
                                    int za, int zb);
        cmd_row_t c;
        c.kind = k;
        c.sx = CW'(sx);
        c.sy = CW'(sy);
        c.ex = CW'(ex);
        c.ey = CW'(ey);
        c.za = DW'(za);
        c.zb = DW'(zb);
        c.typed = 1'b0;
        c.want = '0;
        return c;
    endfunction

    function automatic cmd_row_t mk_typed(cmd_row_t c, int x, int y, int z, bit ins,
                                          int idx, bit lst);
        c.typed = 1'b1;
        c.want = '{x: CW'(x), y: CW'(y), depth: DW'(z), in_view: ins,
                   index: CW'(idx), last: lst};
        return c;
    endfunction

    function automatic int rand_depth();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // receiver: ready with random stalls
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            pix_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            pix_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            pix_ch.ready <= 1'b1;
            stall_left = pick_gap(rx_quiet);
        end
    end

    // compare each pixel transfer against the oldest expected pixel
    always @(posedge clk)
    begin
        pixel_t got, want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got = '{x: pix_ch.pixel_x, y: pix_ch.pixel_y, depth: pix_ch.pixel_depth,
                    in_view: pix_ch.inside_res, index: pix_ch.step_index,
                    last: pix_ch.last};
            if (pending_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel x=%0d y=%0d", $signed(got.x),
                             $signed(got.y));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"pixel mismatch exp x=%0d y=%0d z=%0d in=%0b i=%0d l=%0b",
                                  " | got x=%0d y=%0d z=%0d in=%0b i=%0d l=%0b"},
                                 $signed(want.x), $signed(want.y), want.depth,
                                 want.in_view, want.index, want.last,
                                 $signed(got.x), $signed(got.y), got.depth,
                                 got.in_view, got.index, got.last);
                end
            end
        end
    end

    // hard limit on run length
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial
    begin
        cmd_row_t rows[$];
        cmd_row_t c;
        int cx0, cy0, nsteps, sent, phase, r, span;
        int vw_set[6];
        int vh_set[6];

        cmd_ch.valid = 1'b0;
        cmd_ch.mode = bls_pkg::CMD_STEP;
        cmd_ch.start_x = '0;
        cmd_ch.start_y = '0;
        cmd_ch.end_x = '0;
        cmd_ch.end_y = '0;
        cmd_ch.start_depth = '0;
        cmd_ch.end_depth = '0;
        pix_ch.ready = 1'b0;
        walking = 1'b0;
        seg_len = 0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        rows.insert(rows.size(), mk(bls_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
        rows.insert(rows.size(),
                    mk_typed(mk(bls_pkg::CMD_START, 0, 0, 0, 0, 0, 65535),
                             0, 0, 65535, 1, 0, 1));
        rows.insert(rows.size(), mk(bls_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
        rows.insert(rows.size(),
                    mk_typed(mk(bls_pkg::CMD_START, -8192, -8192, 8191, 8191, 65535, 0),
                             -8192, -8192, 65535, 0, 0, 0));
        repeat (3) rows.insert(rows.size(), mk(bls_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
        rows.insert(rows.size(),
                    mk_typed(mk(bls_pkg::CMD_START, 8191, 8191, 8191, 8191, 65535, 0),
                             8191, 8191, 0, 0, 0, 1));
        rows.insert(rows.size(),
                    mk_typed(mk(bls_pkg::CMD_START, 1023, 0, 1024, 0, 100, 200),
                             1023, 0, 100, 1, 0, 0));
        rows.insert(rows.size(),
                    mk_typed(mk(bls_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0),
                             1024, 0, 200, 0, 1, 1));
        rows.insert(rows.size(), mk(bls_pkg::CMD_START, 5, -3, -4, 7, 30000, 1000));
        repeat (7) rows.insert(rows.size(), mk(bls_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(bls_pkg::CMD_START, 0, 0, 0, -3, 0, 65535));
        repeat (4) rows.insert(rows.size(), mk(bls_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
        foreach (rows[i])
            send_cmd(rows[i]);
        drain();

        // viewport settings per phase, extremes and zero among them
        vw_set = '{1024, 1, 8192, 0, 37, 640};
        vh_set = '{1024, 1, 8192, 8192, 0, 480};
        sent = 0;
        for (phase = 0; phase < 6; phase++)
        begin
            write_reg(bls_pkg::CFG_VIEWPORT_WIDTH, vw_set[phase]);
            write_reg(bls_pkg::CFG_VIEWPORT_HEIGHT, vh_set[phase]);
            while (sent < (phase + 1) * 300)
            begin
                tx_quiet = $urandom_range(0, 9) == 0;
                rx_quiet = $urandom_range(0, 9) == 0;
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    // short line, mostly near the viewport, walked partway, to its end or past it
                    span = $urandom_range(0, 3) == 0 ? 40 : 8;
                    cx0 = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383) - 8192
                                                    : $urandom_range(0, 1100) - 40;
                    cy0 = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383) - 8192
                                                    : $urandom_range(0, 1100) - 40;
                    c = mk(bls_pkg::CMD_START, cx0, cy0,
                           cx0 + $urandom_range(0, 2 * span) - span,
                           cy0 + $urandom_range(0, 2 * span) - span,
                           rand_depth(), rand_depth());
                    send_cmd(c);
                    sent++;
                    nsteps = $urandom_range(0, 2 * span + 3);
                end
                else if (r < 95)
                begin
                    // long line from anywhere, only its beginning walked
                    c = mk(bls_pkg::CMD_START, $urandom_range(0, 16383),
                           $urandom_range(0, 16383),
                           $urandom_range(0, 16383), $urandom_range(0, 16383),
                           rand_depth(), rand_depth());
                    send_cmd(c);
                    sent++;
                    nsteps = $urandom_range(0, 10);
                end
                else
                    nsteps = $urandom_range(1, 3);
                repeat (nsteps)
                begin
                    c = mk(bls_pkg::CMD_STEP, $urandom_range(0, 16383),
                           $urandom_range(0, 16383),
                           $urandom_range(0, 16383), $urandom_range(0, 16383),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
                    sent++;
                    send_cmd(c);
                end
            end
            drain();
        end

        if (errors == 0 && pending_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
